// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/mrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrs_pkg
// Types and codes shared by the matrix rotation store modules.
// ----------------------------------------------------------------------------
package mrs_pkg;

  typedef enum logic [2:0] {
    OP_SET_SIZE = 3'd0,
    OP_WRITE    = 3'd1,
    OP_READ     = 3'd2,
    OP_ROT_R    = 3'd3,
    OP_ROT_L    = 3'd4
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_BUSY = 1'b1
  } state_t;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] row;
    logic [3:0] col;
    logic [4:0] new_rows;
    logic [4:0] new_cols;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       read_valid;
    logic [4:0] view_rows;
    logic [4:0] view_cols;
    logic [1:0] view_turns;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;
  } dp_status_t;

endpackage

// ===== rtl/mrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrs_ctrl
// Controller: takes one transaction, then hands its result to the output.
// ----------------------------------------------------------------------------
module mrs_ctrl
  import mrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       out_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_free;

  assign out_free = !status.out_valid || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_BUSY;
      end
      S_BUSY: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      S_BUSY: begin
        cmd.load_out = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/mrs_datapath.sv =====
// ----------------------------------------------------------------------------
// mrs_datapath
// View state, address remap, element memory and output register.
// ----------------------------------------------------------------------------
module mrs_datapath
  import mrs_pkg::*;
#(
  parameter int SIDE = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  in_item_t   item,
  input  ctrl_cmd_t  cmd,
  input  logic       out_tready,
  output dp_status_t status,
  output out_item_t  result
);

  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CLAMP = (SIDE > 31) ? 31 : SIDE;
  localparam logic [4:0] CLAMP_V = 5'(CLAMP);

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q_r;
  logic       rd_ok_r;

  logic [4:0] stored_rows_r, stored_cols_r;
  logic [1:0] orient_r, qturns_r;
  logic       out_valid_r;
  out_item_t  result_r;

  logic [4:0] view_rows, view_cols;
  logic [4:0] row5, col5, x, y;
  logic       in_bounds;
  logic [AW-1:0] addr;
  op_t        op;

  assign op        = op_t'(item.op);
  assign view_rows = orient_r[0] ? stored_cols_r : stored_rows_r;
  assign view_cols = orient_r[0] ? stored_rows_r : stored_cols_r;
  assign row5      = {1'b0, item.row};
  assign col5      = {1'b0, item.col};
  assign in_bounds = (row5 < view_rows) && (col5 < view_cols);

  // View position to stored position for each orientation.
  always_comb begin
    case (orient_r)
      2'd0: begin
        x = row5;
        y = col5;
      end
      2'd1: begin
        x = stored_rows_r - 5'd1 - col5;
        y = row5;
      end
      2'd2: begin
        x = stored_rows_r - 5'd1 - row5;
        y = stored_cols_r - 5'd1 - col5;
      end
      default: begin
        x = col5;
        y = stored_cols_r - 5'd1 - row5;
      end
    endcase
  end

  assign addr = AW'(x) * AW'(SIDE) + AW'(y);

  always_ff @(posedge clk) begin
    if (cmd.accept && op == OP_WRITE && in_bounds) begin
      mem[addr] <= item.value;
    end
    if (cmd.accept && op == OP_READ && in_bounds) begin
      mem_q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_rows_r <= '0;
      stored_cols_r <= '0;
      orient_r      <= '0;
      qturns_r      <= 2'd1;
      rd_ok_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) qturns_r <= cfg_wr_data;
      if (cmd.accept) begin
        rd_ok_r <= (op == OP_READ) && in_bounds;
        case (op)
          OP_SET_SIZE: begin
            stored_rows_r <= (item.new_rows > CLAMP_V) ? CLAMP_V : item.new_rows;
            stored_cols_r <= (item.new_cols > CLAMP_V) ? CLAMP_V : item.new_cols;
            orient_r      <= '0;
          end
          OP_ROT_R: orient_r <= orient_r + qturns_r;
          OP_ROT_L: orient_r <= orient_r - qturns_r;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_r.read_value <= rd_ok_r ? mem_q_r : 8'd0;
      result_r.read_valid <= rd_ok_r;
      result_r.view_rows  <= view_rows;
      result_r.view_cols  <= view_cols;
      result_r.view_turns <= orient_r;
    end
  end

  assign status.out_valid = out_valid_r;
  assign result           = result_r;

endmodule

// ===== rtl/matrix_rotation_store.sv =====
// ----------------------------------------------------------------------------
// matrix_rotation_store
// Character matrix behind a rotatable view, driven by a stream of ops.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one op in in_tuser (set size, write,
// read, rotate right, rotate left) and its operands in in_tdata. Every op
// gives exactly one result transaction with the read byte, a read-valid flag
// in out_tuser, and the view's row count, column count and orientation as
// they stand after the op.
// Timing: an op is taken while the controller is idle; the element memory is
// read or written at that accepting edge, and the result enters the output
// register in the controller's drain step once the output register is free,
// which raises out_tvalid. Each op passes the accept and drain steps, and the
// controller takes no new op until the last result has entered the register.
// Stalls: a result waiting on out_tready holds in the output register while
// the next op is accepted; that op then waits in the controller until the
// output register frees.
// Reset: rst_n clears the view to zero rows, zero columns and no turn, and
// sets the turn step to one quarter turn. The element memory is not cleared;
// an entry reads back only after it was written. cfg_wr_en writes the turn
// step and should only be used while no op is in flight.
// ----------------------------------------------------------------------------
module matrix_rotation_store
  import mrs_pkg::*;
#(
  parameter int SIDE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: quarter turns per rotate op.
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, low bit up: row[3:0], col[7:4], new_rows[12:8],
  // new_cols[17:13], value[25:18], zero fill [31:26].
  input  logic [31:0] in_tdata,
  // in_tuser: op[2:0].
  input  logic [2:0]  in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, low bit up: read_value[7:0], view_rows[12:8],
  // view_cols[17:13], view_turns[19:18], zero fill [23:20].
  output logic [23:0] out_tdata,
  // out_tuser: read_valid.
  output logic        out_tuser
);

  in_item_t   item;
  out_item_t  result;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Unpack the transaction into its fields.
  assign item.op       = in_tuser;
  assign item.row      = in_tdata[3:0];
  assign item.col      = in_tdata[7:4];
  assign item.new_rows = in_tdata[12:8];
  assign item.new_cols = in_tdata[17:13];
  assign item.value    = in_tdata[25:18];

  mrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mrs_datapath #(
    .SIDE (SIDE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .cmd         (cmd),
    .out_tready  (out_tready),
    .status      (status),
    .result      (result)
  );

  // The output register lives in the datapath; pack it for the bus.
  assign out_tvalid = status.out_valid;
  assign out_tuser  = result.read_valid;
  assign out_tdata  = {4'd0, result.view_turns, result.view_cols,
                       result.view_rows, result.read_value};

endmodule

// ===== rtl/mrs_checker.sv =====
// ----------------------------------------------------------------------------
// mrs_checker
// Port-level checks of the matrix rotation store, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrs_checker #(
  parameter int SIDE = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  localparam int CLAMP = (SIDE > 31) ? 31 : SIDE;
  localparam logic [4:0] CLAMP_V = 5'(CLAMP);

  // A held result stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

  // Only one op is in the controller at a time.
  `ASSERT_NEXT(a_one_op, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // A result without a valid read carries a zero byte.
  `ASSERT_SAME(a_zero_byte, clk, rst_n, out_tvalid && !out_tuser, out_tdata[7:0] == 8'd0)

  // The view never exceeds the matrix side.
  `ASSERT_SAME(a_view_size, clk, rst_n, out_tvalid,
    (out_tdata[12:8] <= CLAMP_V) && (out_tdata[17:13] <= CLAMP_V))

endmodule

bind matrix_rotation_store mrs_checker #(.SIDE(SIDE)) u_mrs_checker (.*);
